>>> rtl/odometer_trip_meter_macros.svh
// Assertion macros for the odometer trip meter.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef ODOMETER_TRIP_METER_MACROS_SVH
`define ODOMETER_TRIP_METER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define OTM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("odometer_trip_meter: assertion failed");
// next-cycle implication
`define OTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("odometer_trip_meter: assertion failed");
`else
`define OTM_ASSERT_IMP(lbl, ante, cons)
`define OTM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/otm_pkg.sv
// Types and constants shared by the odometer trip meter and its interfaces.
// No dependencies.
package otm_pkg;

    localparam logic [31:0] METRE_MM      = 32'd1000;
    localparam logic [29:0] TOTAL_LIMIT_M = 30'd1000000000;
    localparam logic [19:0] TRIP_LIMIT_M  = 20'd1000000;

    // register indexes
    localparam logic [7:0] REG_TICK_PERIOD   = 8'd0;
    localparam logic [7:0] REG_UPDATE_PERIOD = 8'd1;
    localparam logic [7:0] REG_REPORT_STEP   = 8'd2;
    localparam logic [7:0] REG_SAVE_PERIOD   = 8'd3;

    // register reset values
    localparam logic [7:0]  RST_TICK_PERIOD   = 8'd10;
    localparam logic [15:0] RST_UPDATE_PERIOD = 16'd1000;
    localparam logic [7:0]  RST_REPORT_STEP   = 8'd100;
    localparam logic [15:0] RST_SAVE_PERIOD   = 16'd30000;

    typedef logic [7:0]  t_cfg_index;
    typedef logic [15:0] t_cfg_data;

    typedef struct packed {
        logic [15:0] added_mm;
        logic [15:0] save_elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [29:0] total_m;
        logic [19:0] trip_m;
        logic        report_total;
        logic        report_trip;
        logic        save_request;
    } t_out_item;

endpackage

>>> rtl/otm_in_if.sv
// Tick input channel: valid/ready handshake with one tick item.
// Depends on otm_pkg.
interface otm_in_if;
    import otm_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/otm_out_if.sv
// Result channel: valid/ready handshake with one mileage result item.
// Depends on otm_pkg.
interface otm_out_if;
    import otm_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/otm_cfg_if.sv
// Configuration write channel: valid/ready with register index and write data.
// Depends on otm_pkg.
interface otm_cfg_if;
    import otm_pkg::*;
    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_cfg_data  wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/odometer_trip_meter.sv
// Odometer trip meter: each tick item updates distance, counts and timers.
// Depends on otm_pkg, otm_in_if, otm_out_if, otm_cfg_if and the macros header.
//
// Usage:
//   i_in  : one item per scan tick (added_mm, save_elapsed_ms).
//   o_out : one result item per tick (total_m, trip_m, report_total,
//           report_trip, save_request).
//   i_cfg : register writes (0 tick period, 1 update period, 2 report step,
//           3 save period); always ready, other indexes are ignored.
// The state registers update at the edge that takes the item, and its result
// sits in the output register from the next cycle.
// Throughput is one item per cycle while the receiver takes each result; the single output register sets it.
// The input is ready whenever the output register is empty or being drained,
// so a stalled receiver holds the result and stops intake until it takes it.
// Reset (synchronous, active low) clears all counts and timers, empties the
// output register and loads the register defaults 10, 1000, 100 and 30000.
`include "odometer_trip_meter_macros.svh"

module odometer_trip_meter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    otm_in_if.sink        i_in,
    otm_out_if.source     o_out,
    otm_cfg_if.sink       i_cfg
);
    import otm_pkg::*;

    // configuration
    logic [7:0]  r_tick_period;
    logic [15:0] r_update_period;
    logic [7:0]  r_report_step;
    logic [15:0] r_save_period;

    // mileage state
    logic [31:0] r_dist,       n_dist;
    logic [16:0] r_save_timer, n_save_timer;
    logic [15:0] r_upd_timer,  n_upd_timer;
    logic [29:0] r_total,      n_total;
    logic [19:0] r_trip,       n_trip;
    logic [29:0] r_last_total, n_last_total;
    logic [19:0] r_last_trip,  n_last_trip;

    logic        r_out_valid;
    t_out_item   r_out, n_out;

    logic        in_acc;
    logic [32:0] dist_sum;
    logic [31:0] dist_sat;
    logic [17:0] save_sum;
    logic [16:0] save_sat;
    logic [16:0] upd_sum;
    logic [15:0] upd_sat;
    logic        metre, save_hit, upd_hit, rep_total_step, rep_trip_step;
    logic [29:0] total_diff;
    logic [19:0] trip_diff;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        dist_sum = {1'b0, r_dist} + {17'd0, i_in.data.added_mm};
        dist_sat = dist_sum[32] ? '1 : dist_sum[31:0];
        save_sum = {1'b0, r_save_timer} + {2'd0, i_in.data.save_elapsed_ms};
        save_sat = save_sum[17] ? '1 : save_sum[16:0];
        upd_sum  = {1'b0, r_upd_timer} + {9'd0, r_tick_period};
        upd_sat  = upd_sum[16] ? '1 : upd_sum[15:0];

        save_hit     = save_sat >= {1'b0, r_save_period};
        n_save_timer = save_hit ? '0 : save_sat;

        metre  = dist_sat >= METRE_MM;
        n_dist = metre ? dist_sat - METRE_MM : dist_sat;
        n_total = (metre && r_total < TOTAL_LIMIT_M) ? r_total + 30'd1 : r_total;
        n_trip  = (metre && r_trip < TRIP_LIMIT_M) ? r_trip + 20'd1 : r_trip;

        // counts only grow, the >= guard mirrors the unsigned-wrap check
        total_diff     = n_total - r_last_total;
        trip_diff      = n_trip - r_last_trip;
        rep_total_step = (total_diff > {22'd0, r_report_step}) && (n_total >= r_last_total);
        rep_trip_step  = (trip_diff > {12'd0, r_report_step}) && (n_trip >= r_last_trip);
        n_last_total   = rep_total_step ? n_total : r_last_total;
        n_last_trip    = rep_trip_step ? n_trip : r_last_trip;

        // periodic report forces both flags, last-report values untouched
        upd_hit     = upd_sat >= r_update_period;
        n_upd_timer = upd_hit ? '0 : upd_sat;

        n_out.total_m      = n_total;
        n_out.trip_m       = n_trip;
        n_out.report_total = rep_total_step || upd_hit;
        n_out.report_trip  = rep_trip_step || upd_hit;
        n_out.save_request = save_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period   <= RST_TICK_PERIOD;
            r_update_period <= RST_UPDATE_PERIOD;
            r_report_step   <= RST_REPORT_STEP;
            r_save_period   <= RST_SAVE_PERIOD;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_TICK_PERIOD:   r_tick_period   <= i_cfg.wdata[7:0];
                REG_UPDATE_PERIOD: r_update_period <= i_cfg.wdata;
                REG_REPORT_STEP:   r_report_step   <= i_cfg.wdata[7:0];
                REG_SAVE_PERIOD:   r_save_period   <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist       <= '0;
            r_save_timer <= '0;
            r_upd_timer  <= '0;
            r_total      <= '0;
            r_trip       <= '0;
            r_last_total <= '0;
            r_last_trip  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_dist       <= n_dist;
                r_save_timer <= n_save_timer;
                r_upd_timer  <= n_upd_timer;
                r_total      <= n_total;
                r_trip       <= n_trip;
                r_last_total <= n_last_total;
                r_last_trip  <= n_last_trip;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    `OTM_ASSERT_NEXT(a_save_clears, in_acc && save_hit, r_save_timer == 17'd0)
    `OTM_ASSERT_IMP(a_last_le_count, 1'b1, r_last_total <= r_total && r_last_trip <= r_trip)
    `OTM_ASSERT_IMP(a_count_limits, 1'b1, r_total <= TOTAL_LIMIT_M && r_trip <= TRIP_LIMIT_M)
    `OTM_ASSERT_NEXT(a_one_metre, in_acc, (r_total - $past(r_total)) <= 30'd1)
    `OTM_ASSERT_NEXT(a_idle_holds, !in_acc, $stable(r_total) && $stable(r_dist))

endmodule
